FILE: rtl/huffman_code_builder_core_defines.svh
// Assertion macros for the Huffman code builder
`ifndef HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hcb_pkg.sv
// Package: constants and status codes of the Huffman code builder
`timescale 1ns / 1ps
package hcb_pkg;
  localparam int unsigned MaxSymbolsDef = 64;
  localparam int unsigned MaxCodeLenDef = 32;
  localparam int unsigned WeightW       = 16;
  localparam int unsigned NodeWeightW   = 22;
  localparam int unsigned IndexW        = 6;
  localparam int unsigned CodeW         = 32;
  localparam int unsigned LenW          = 6;
  localparam int unsigned StatusW       = 2;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StFew     = 2'd1;
  localparam logic [StatusW-1:0] StMany    = 2'd2;
  localparam logic [StatusW-1:0] StTooLong = 2'd3;
endpackage

FILE: rtl/hcb_intf.sv
// Interfaces: weight input channel and code output channel
`timescale 1ns / 1ps
interface hcb_in_if import hcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WeightW-1:0] weight;
  logic               last;
  modport source (output valid, output weight, output last, input ready);
  modport sink   (input valid, input weight, input last, output ready);
endinterface

interface hcb_out_if import hcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IndexW-1:0]  leaf_index;
  logic [CodeW-1:0]   code_bits;
  logic [LenW-1:0]    code_length;
  logic [StatusW-1:0] status;
  logic               final_res;
  modport source (output valid, output leaf_index, output code_bits, output code_length,
                  output status, output final_res, input ready);
  modport sink   (input valid, input leaf_index, input code_bits, input code_length,
                  input status, input final_res, output ready);
endinterface

FILE: rtl/huffman_code_builder_core.sv
// Huffman code builder: leaf load, tree build by merge scans, code walk per leaf
// Build: a weight without last is stored while idle. On last, each merge scans every node
// so far through the single weight-memory read port, then the walk climbs from each leaf
// to the root one tree level per step (SWPar, SWLeft, SWStep) and emits its code in SEmit.
// Throughput: one item at a time; input is ready only while no build or walk runs.
// Reset: asynchronous active low; clears leaf count, overflow flag, state and output valid.
`timescale 1ns / 1ps
`include "huffman_code_builder_core_defines.svh"
module huffman_code_builder_core import hcb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS  = MaxSymbolsDef,
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcb_in_if.sink    in_i,
  hcb_out_if.source out_o
);
  localparam int unsigned NodeDepth = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned NW        = $clog2(2 * MAX_SYMBOLS);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SScan  = 4'd1;
  localparam logic [3:0] SMrgA  = 4'd2;
  localparam logic [3:0] SMrgB  = 4'd3;
  localparam logic [3:0] SWPar  = 4'd4;
  localparam logic [3:0] SWLeft = 4'd5;
  localparam logic [3:0] SWStep = 4'd6;
  localparam logic [3:0] SEmit  = 4'd7;
  localparam logic [3:0] SErr   = 4'd8;

  logic [NodeWeightW-1:0] weight_mem [NodeDepth];
  logic [NW-1:0]          par_mem    [NodeDepth];
  logic [NW-1:0]          left_mem   [NodeDepth];

  logic [3:0]             state_q, state_d;
  logic [NW-1:0]          cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [NW-1:0]          n_q, n_d;
  logic [NW-1:0]          i_q, i_d;
  logic [NW-1:0]          j_q, j_d;
  logic                   rv_q, rv_d;
  logic [NW-1:0]          rj_q, rj_d;
  logic [NW-1:0]          b1_q, b1_d, b2_q, b2_d;
  logic [NodeWeightW-1:0] w1_q, w1_d, w2_q, w2_d;
  logic                   f1_q, f1_d, f2_q, f2_d;
  logic [NodeDepth-1:0]   hasp_q, hasp_d;
  logic [NW-1:0]          c_q, c_d;
  logic [NW-1:0]          leaf_q, leaf_d;
  logic [LenW-1:0]        depth_q, depth_d;
  logic [CodeW-1:0]       code_q, code_d;
  logic [StatusW-1:0]     err_q, err_d;

  logic [NodeWeightW-1:0] w_rd_q;
  logic [NW-1:0]          par_rd_q, left_rd_q;

  logic                   w_we, p_we, l_we;
  logic [NW-1:0]          w_wa, p_wa;
  logic [NodeWeightW-1:0] w_wd;

  logic                   ov_q, ov_d;
  logic [IndexW-1:0]      o_idx_q, o_idx_d;
  logic [CodeW-1:0]       o_code_q, o_code_d;
  logic [LenW-1:0]        o_len_q, o_len_d;
  logic [StatusW-1:0]     o_st_q, o_st_d;
  logic                   o_fin_q, o_fin_d;

  logic                   in_fire, slot_free, full;
  logic [NW-1:0]          n_new;

  assign in_i.ready        = (state_q == SIdle);
  assign in_fire           = in_i.valid & in_i.ready;
  assign slot_free         = ~ov_q | out_o.ready;
  assign full              = (cnt_q == NW'(MAX_SYMBOLS));
  assign n_new             = full ? cnt_q : cnt_q + NW'(1);

  assign out_o.valid       = ov_q;
  assign out_o.leaf_index  = o_idx_q;
  assign out_o.code_bits   = o_code_q;
  assign out_o.code_length = o_len_q;
  assign out_o.status      = o_st_q;
  assign out_o.final_res   = o_fin_q;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;    ovf_d = ovf_q;   n_d = n_q;
    i_d = i_q;          j_d = j_q;        rv_d = 1'b0;     rj_d = j_q;
    b1_d = b1_q;        b2_d = b2_q;      w1_d = w1_q;     w2_d = w2_q;
    f1_d = f1_q;        f2_d = f2_q;      hasp_d = hasp_q; c_d = c_q;
    leaf_d = leaf_q;    depth_d = depth_q; code_d = code_q; err_d = err_q;
    w_we = 1'b0;        w_wa = cnt_q;     w_wd = NodeWeightW'(in_i.weight);
    p_we = 1'b0;        p_wa = b1_q;      l_we = 1'b0;
    ov_d = ov_q & ~out_o.ready;
    o_idx_d = o_idx_q;  o_code_d = o_code_q; o_len_d = o_len_q;
    o_st_d = o_st_q;    o_fin_d = o_fin_q;

    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            w_we  = 1'b1;
            cnt_d = cnt_q + NW'(1);
          end
          if (in_i.last) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            n_d   = n_new;
            if (ovf_q | full) begin
              err_d = StMany;  state_d = SErr;
            end else if (n_new < NW'(2)) begin
              err_d = StFew;   state_d = SErr;
            end else begin
              hasp_d = '0;  i_d = n_new;  j_d = '0;
              f1_d = 1'b0;  f2_d = 1'b0;  state_d = SScan;
            end
          end
        end
      end
      SScan: begin
        if (j_q != i_q) begin
          rv_d = 1'b1;
          j_d  = j_q + NW'(1);
        end
        if (rv_q && !hasp_q[rj_q]) begin
          if (!f1_q || w_rd_q < w1_q) begin
            b2_d = b1_q;  w2_d = w1_q;  f2_d = f1_q;
            b1_d = rj_q;  w1_d = w_rd_q; f1_d = 1'b1;
          end else if (!f2_q || w_rd_q < w2_q) begin
            b2_d = rj_q;  w2_d = w_rd_q; f2_d = 1'b1;
          end
        end
        if (j_q == i_q && !rv_q) state_d = SMrgA;
      end
      SMrgA: begin
        w_we = 1'b1;  w_wa = i_q;  w_wd = w1_q + w2_q;
        p_we = 1'b1;  p_wa = b1_q; l_we = 1'b1;
        hasp_d[b1_q] = 1'b1;
        state_d = SMrgB;
      end
      SMrgB: begin
        p_we = 1'b1;  p_wa = b2_q;
        hasp_d[b2_q] = 1'b1;
        i_d = i_q + NW'(1);
        j_d = '0;  f1_d = 1'b0;  f2_d = 1'b0;
        if (i_q + NW'(1) == n_q + n_q - NW'(1)) begin
          leaf_d = '0;  c_d = '0;  depth_d = '0;  code_d = '0;
          state_d = SWPar;
        end else begin
          state_d = SScan;
        end
      end
      SWPar:  state_d = hasp_q[c_q] ? SWLeft : SEmit;
      SWLeft: state_d = SWStep;
      SWStep: begin
        if (left_rd_q != c_q) code_d = code_q | (CodeW'(1) << depth_q);
        depth_d = depth_q + LenW'(1);
        c_d     = par_rd_q;
        state_d = SWPar;
      end
      SEmit: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          o_idx_d = IndexW'(leaf_q);
          o_len_d = depth_q;
          o_fin_d = (leaf_q + NW'(1) == n_q);
          if (depth_q > LenW'(MAX_CODE_LEN)) begin
            o_code_d = '0;      o_st_d = StTooLong;
          end else begin
            o_code_d = code_q;  o_st_d = StOk;
          end
          leaf_d = leaf_q + NW'(1);  c_d = leaf_q + NW'(1);
          depth_d = '0;  code_d = '0;
          state_d = (leaf_q + NW'(1) == n_q) ? SIdle : SWPar;
        end
      end
      SErr: begin
        if (slot_free) begin
          ov_d = 1'b1;  o_idx_d = '0;  o_code_d = '0;  o_len_d = '0;
          o_st_d = err_q;  o_fin_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (w_we) weight_mem[w_wa] <= w_wd;
    if (p_we) par_mem[p_wa] <= i_q;
    if (l_we) left_mem[i_q] <= b1_q;
    w_rd_q    <= weight_mem[j_q];
    par_rd_q  <= par_mem[c_q];
    left_rd_q <= left_mem[par_rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;       i_q <= i_d;       j_q <= j_d;       rj_q <= rj_d;
    b1_q <= b1_d;     b2_q <= b2_d;     w1_q <= w1_d;     w2_q <= w2_d;
    f1_q <= f1_d;     f2_q <= f2_d;     hasp_q <= hasp_d; c_q <= c_d;
    leaf_q <= leaf_d; depth_q <= depth_d; code_q <= code_d; err_q <= err_d;
    o_idx_q <= o_idx_d; o_code_q <= o_code_d; o_len_q <= o_len_d;
    o_st_q <= o_st_d;   o_fin_q <= o_fin_d;
  end

  `HCB_ASSERT_NOW(a_scan_bound, state_q == SScan, j_q <= i_q, "scan ran past new node")
  `HCB_ASSERT_NOW(a_merge_pair, state_q == SMrgA, f1_q && f2_q && b1_q != b2_q, "bad merge pair")
  `HCB_ASSERT_NEXT(a_err_done, state_q == SErr && slot_free, state_q == SIdle && ov_q, "error item lost")
  `HCB_ASSERT_NOW(a_ok_len, ov_q && o_st_q == StOk, o_len_q != '0, "zero-length code")
endmodule

FILE: tb/sv/huffman_code_builder_core_test.sv
// Testbench for the Huffman code builder: weight packets in, per-leaf codes checked against a local tree build
`timescale 1ns / 1ps
module huffman_code_builder_core_test;
  import hcb_pkg::*;

  localparam int unsigned NSym = MaxSymbolsDef;
  localparam int unsigned MaxLen = MaxCodeLenDef;
  localparam int unsigned NNodes = 127;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [IndexW-1:0]  leaf_index;
    logic [CodeW-1:0]   code_bits;
    logic [LenW-1:0]    code_length;
    logic [StatusW-1:0] status;
    logic               final_res;
  } code_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcb_in_if  in_ch ();
  hcb_out_if out_ch ();

  huffman_code_builder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  code_rec_t       pending_codes[$];
  logic [21:0]     tree_weight[NNodes];
  logic [6:0]      tree_parent[NNodes];
  logic [6:0]      tree_left[NNodes];
  int unsigned     loaded_leaves;
  bit              leaf_overflow;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     recv_hold;
  int unsigned     mismatches;
  int unsigned     items_sent;
  int unsigned     codes_seen;
  int unsigned     packets_built;
  longint unsigned cycle_count;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.weight = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d codes pending", cycle_count, pending_codes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold    <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h (code %0d)", what, got, want, codes_seen);
  endtask

  always @(posedge clk_i) begin
    code_rec_t got;
    code_rec_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.leaf_index  = out_ch.leaf_index;
      got.code_bits   = out_ch.code_bits;
      got.code_length = out_ch.code_length;
      got.status      = out_ch.status;
      got.final_res   = out_ch.final_res;
      codes_seen++;
      if (pending_codes.size() == 0) begin
        report("unexpected code", got, 0);
      end else begin
        want = pending_codes.pop_front();
        if (got.leaf_index != want.leaf_index)
          report("leaf_index", got.leaf_index, want.leaf_index);
        if (got.code_bits != want.code_bits)
          report("code_bits", got.code_bits, want.code_bits);
        if (got.code_length != want.code_length)
          report("code_length", got.code_length, want.code_length);
        if (got.status != want.status)
          report("status", got.status, want.status);
        if (got.final_res != want.final_res)
          report("final_res", got.final_res, want.final_res);
      end
    end
  end

  function automatic int unsigned least_free(int unsigned limit, int unsigned skip);
    int unsigned best;
    bit          found;
    best  = 0;
    found = 0;
    for (int unsigned j = 0; j < limit; j++) begin
      if (j != skip && tree_parent[j] == 0) begin
        if (!found || tree_weight[j] < tree_weight[best]) begin
          best  = j;
          found = 1;
        end
      end
    end
    return best;
  endfunction

  task automatic push_code(int unsigned idx, logic [63:0] code, int unsigned len,
                           logic [StatusW-1:0] st, bit fin);
    code_rec_t r;
    r.leaf_index  = idx[IndexW-1:0];
    r.code_bits   = code[CodeW-1:0];
    r.code_length = len[LenW-1:0];
    r.status      = st;
    r.final_res   = fin;
    pending_codes.push_back(r);
  endtask

  task automatic build_codes(input logic [WeightW-1:0] w, input bit last);
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned f;
    int unsigned depth;
    logic [63:0] code;
    if (loaded_leaves < NSym) begin
      tree_weight[loaded_leaves] = w;
      loaded_leaves++;
    end else begin
      leaf_overflow = 1;
    end
    if (!last) return;
    n = loaded_leaves;
    packets_built++;
    if (leaf_overflow) begin
      push_code(0, 0, 0, StMany, 1);
    end else if (n < 2) begin
      push_code(0, 0, 0, StFew, 1);
    end else begin
      for (int unsigned i = 0; i < 2 * n - 1; i++) tree_parent[i] = 0;
      for (int unsigned i = n; i < 2 * n - 1; i++) begin
        a = least_free(i, NNodes);
        b = least_free(i, a);
        tree_parent[a] = i[6:0];
        tree_parent[b] = i[6:0];
        tree_left[i]   = a[6:0];
        tree_weight[i] = tree_weight[a] + tree_weight[b];
      end
      for (int unsigned leaf = 0; leaf < n; leaf++) begin
        code  = 0;
        depth = 0;
        c     = leaf;
        f     = tree_parent[leaf];
        while (f != 0 && depth < 63) begin
          if (tree_left[f] != c) code[depth] = 1'b1;
          depth++;
          c = f;
          f = tree_parent[f];
        end
        if (depth > MaxLen) push_code(leaf, 0, depth, StTooLong, leaf + 1 == n);
        else push_code(leaf, code, depth, StOk, leaf + 1 == n);
      end
    end
    loaded_leaves = 0;
    leaf_overflow = 0;
  endtask

  task automatic send_weight(input logic [WeightW-1:0] w, input bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.weight <= w;
    in_ch.last   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    build_codes(w, last);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return WeightW'($urandom_range(15));
      default: return WeightW'($urandom);
    endcase
  endfunction

  task automatic send_packet(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_weight(rand_weight(), i + 1 == len);
  endtask

  task automatic test_directed();
    send_weight(16'h0000, 0);
    send_weight(16'hFFFF, 1);
    send_weight(16'h1234, 1);
    for (int i = 0; i < 3; i++) send_weight(16'd5, i == 2);
    for (int i = 0; i < 8; i++) send_weight(16'd1 << i, i == 7);
    send_weight(16'hFFFF, 0);
    send_weight(16'hFFFF, 0);
    send_weight(16'h0000, 0);
    send_weight(16'hAAAA, 0);
    send_weight(16'h5555, 1);
    wait_drained();
  endtask

  task automatic test_deep_tree();
    int unsigned fa;
    int unsigned fb;
    int unsigned t;
    fa = 1;
    fb = 1;
    for (int i = 0; i < 24; i++) begin
      send_weight(fa[WeightW-1:0], i == 23);
      t  = fa + fb;
      fa = fb;
      fb = t;
    end
    wait_drained();
  endtask

  task automatic test_full_and_overflow();
    for (int i = 0; i < NSym + 1; i++) send_weight(rand_weight(), i == NSym);
    for (int i = 0; i < NSym; i++) send_weight(16'hFFFF, i == NSym - 1);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    recv_hold = 600;
    send_packet(20);
    send_packet(12);
    send_packet(5);
    wait_drained();
  endtask

  task automatic test_random(int unsigned budget);
    int unsigned start;
    int unsigned len;
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(19))
        0: len = 1;
        1: len = $urandom_range(NSym - 8, NSym);
        default: len = $urandom_range(2, 12);
      endcase
      send_packet(len);
    end
    wait_drained();
  endtask

  initial begin
    loaded_leaves = 0;
    leaf_overflow = 0;
    recv_hold     = 0;
    mismatches    = 0;
    items_sent    = 0;
    codes_seen    = 0;
    packets_built = 0;
    cycle_count   = 0;
    send_idle_pct = 27;
    recv_idle_pct = 51;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_deep_tree();
    test_full_and_overflow();
    test_random(20);
    send_idle_pct = 51;
    recv_idle_pct = 27;
    test_back_pressure();
    test_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(15);

    repeat (200) @(posedge clk_i);
    $display("covered %0d weights in %0d packets, %0d codes checked", items_sent,
             packets_built, codes_seen);
    $display("included single leaf, full and overflowing packets, deep trees, back pressure");
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/hcb_pkg.sv
rtl/hcb_intf.sv
rtl/huffman_code_builder_core.sv
tb/sv/huffman_code_builder_core_test.sv
